[rtl/r2e_pkg.sv]
package r2e_pkg;

   localparam int ENTRY_W      = 18;
   localparam int LIMIT_W      = 17;
   localparam int ANGLE_W      = 16;
   localparam int SQ_W         = 35;
   localparam int SUM_W        = 36;
   localparam int ROOT_W       = 18;
   localparam int REM_W        = 19;
   localparam int OPD_W        = 19;
   localparam int CW           = 27;
   localparam int LANES        = 3;
   localparam int CORDIC_ITERS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int CORDIC_STEPS = (CORDIC_ITERS < ATAN_LEN) ? CORDIC_ITERS : ATAN_LEN;
   localparam int PRESCALE     = 6;
   localparam int ROUND_SH     = 9;
   localparam int RES_W        = CW - ROUND_SH;

   localparam logic signed [CW-1:0]    DEG180   = CW'(11796480);
   localparam logic signed [CW-1:0]    ROUND_HALF = CW'(256);
   localparam logic signed [RES_W-1:0] OUT_MAX  = RES_W'(23040);
   localparam logic [LIMIT_W-1:0]      LIMIT_RESET = LIMIT_W'(1);

   // Lane order of the angle unit
   localparam int LANE_YAW   = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_ROLL  = 2;

   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef logic signed [OPD_W-1:0]   opd_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;

   typedef struct packed {
      entry_type r00;
      entry_type r10;
      entry_type r20;
      entry_type r21;
      entry_type r22;
      entry_type r12;
      entry_type r11;
   } mat_type;

   // atan(2^-i) in degrees, 16 fraction bits
   function automatic logic signed [CW-1:0] atan_deg(input int i);
      logic signed [CW-1:0] v;
      case (i)
         0:  v = CW'(2949120);
         1:  v = CW'(1740967);
         2:  v = CW'(919879);
         3:  v = CW'(466945);
         4:  v = CW'(234379);
         5:  v = CW'(117304);
         6:  v = CW'(58666);
         7:  v = CW'(29335);
         8:  v = CW'(14668);
         9:  v = CW'(7334);
         10: v = CW'(3667);
         11: v = CW'(1833);
         12: v = CW'(917);
         13: v = CW'(458);
         14: v = CW'(229);
         15: v = CW'(115);
         16: v = CW'(57);
         17: v = CW'(29);
         18: v = CW'(14);
         19: v = CW'(7);
         20: v = CW'(4);
         21: v = CW'(2);
         22: v = CW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[rtl/r2e_square.sv]
module r2e_square import r2e_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  mat_type            in_mat,
   output logic               out_valid,
   output logic [SUM_W-1:0]   out_sum,
   output mat_type            out_mat
);

   logic             vld_ff [3];
   mat_type          mat_ff [3];
   logic [SQ_W-1:0]  sq0_ff, sq1_ff;
   logic [SUM_W-1:0] sum_ff;
   logic signed [2*ENTRY_W-1:0] p0_in, p1_in;

   assign p0_in = mat_ff[0].r00 * mat_ff[0].r00;
   assign p1_in = mat_ff[0].r10 * mat_ff[0].r10;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
         vld_ff[1] <= 1'b0;
         vld_ff[2] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         vld_ff[1] <= vld_ff[0];
         vld_ff[2] <= vld_ff[1];
      end
   end

   // capture, square, sum
   always_ff @(posedge clock) begin
      if (en) begin
         mat_ff[0] <= in_mat;
         mat_ff[1] <= mat_ff[0];
         mat_ff[2] <= mat_ff[1];
         sq0_ff    <= p0_in[SQ_W-1:0];
         sq1_ff    <= p1_in[SQ_W-1:0];
         sum_ff    <= {1'b0, sq0_ff} + {1'b0, sq1_ff};
      end
   end

   assign out_valid = vld_ff[2];
   assign out_sum   = sum_ff;
   assign out_mat   = mat_ff[2];

endmodule

[rtl/r2e_isqrt.sv]
module r2e_isqrt import r2e_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [SUM_W-1:0]   in_sum,
   input  mat_type            in_mat,
   output logic               out_valid,
   output logic [ROOT_W-1:0]  out_root,
   output mat_type            out_mat
);

   // one root bit per stage, restoring
   logic              vld_ff  [1:ROOT_W];
   logic [REM_W-1:0]  rem_ff  [1:ROOT_W];
   logic [ROOT_W-1:0] root_ff [1:ROOT_W];
   logic [SUM_W-1:0]  num_ff  [1:ROOT_W];
   mat_type           mat_ff  [1:ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic              vld_cur;
      logic [REM_W-1:0]  rem_cur;
      logic [ROOT_W-1:0] root_cur;
      logic [SUM_W-1:0]  num_cur;
      mat_type           mat_cur;
      logic [REM_W+1:0]  cat;
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  diff;
      logic              take;

      if (s == 0) begin : g_first
         assign vld_cur  = in_valid;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign num_cur  = in_sum;
         assign mat_cur  = in_mat;
      end else begin : g_next
         assign vld_cur  = vld_ff[s];
         assign rem_cur  = rem_ff[s];
         assign root_cur = root_ff[s];
         assign num_cur  = num_ff[s];
         assign mat_cur  = mat_ff[s];
      end

      assign cat   = {rem_cur, num_cur[SUM_W-1 -: 2]};
      assign trial = {1'b0, root_cur, 2'b01};
      assign take  = cat >= trial;
      assign diff  = cat - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (en) begin
            vld_ff[s+1] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1]  <= take ? diff[REM_W-1:0] : cat[REM_W-1:0];
            root_ff[s+1] <= {root_cur[ROOT_W-2:0], take};
            num_ff[s+1]  <= {num_cur[SUM_W-3:0], 2'b00};
            mat_ff[s+1]  <= mat_cur;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_mat   = mat_ff[ROOT_W];

endmodule

[rtl/r2e_cordic.sv]
module r2e_cordic import r2e_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  logic       in_tag,
   input  opd_type    in_y [LANES],
   input  opd_type    in_x [LANES],
   output logic       out_valid,
   output logic       out_tag,
   output angle_type  out_angle [LANES]
);

   // stage 0 holds the pre-rotated operands, stage k the result of step k-1
   logic                 vld_ff  [0:CORDIC_STEPS];
   logic                 tag_ff  [0:CORDIC_STEPS];
   logic signed [CW-1:0] x_ff    [0:CORDIC_STEPS][LANES];
   logic signed [CW-1:0] y_ff    [0:CORDIC_STEPS][LANES];
   logic signed [CW-1:0] z_ff    [0:CORDIC_STEPS][LANES];
   logic                 zero_ff [0:CORDIC_STEPS][LANES];
   logic                 out_vld_ff;
   logic                 out_tag_ff;
   angle_type            ang_ff  [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0]  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0]  <= in_valid;
         out_vld_ff <= vld_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0]  <= in_tag;
         out_tag_ff <= tag_ff[CORDIC_STEPS];
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [CW-1:0] xs, ys;
      logic signed [CW-1:0] zr;
      logic signed [RES_W-1:0] res;

      // scale by 64, fold the left half plane onto the right
      assign xs = {{(CW-OPD_W-PRESCALE){in_x[l][OPD_W-1]}}, in_x[l], {PRESCALE{1'b0}}};
      assign ys = {{(CW-OPD_W-PRESCALE){in_y[l][OPD_W-1]}}, in_y[l], {PRESCALE{1'b0}}};

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[0][l] <= (in_x[l] == '0) && (in_y[l] == '0);
            if (xs < 0) begin
               x_ff[0][l] <= -xs;
               y_ff[0][l] <= -ys;
               z_ff[0][l] <= (ys >= 0) ? DEG180 : -DEG180;
            end else begin
               x_ff[0][l] <= xs;
               y_ff[0][l] <= ys;
               z_ff[0][l] <= '0;
            end
         end
      end

      // vectoring steps
      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
         always_ff @(posedge clock) begin
            if (en) begin
               zero_ff[i+1][l] <= zero_ff[i][l];
               if (y_ff[i][l] >= 0) begin
                  x_ff[i+1][l] <= x_ff[i][l] + (y_ff[i][l] >>> i);
                  y_ff[i+1][l] <= y_ff[i][l] - (x_ff[i][l] >>> i);
                  z_ff[i+1][l] <= z_ff[i][l] + atan_deg(i);
               end else begin
                  x_ff[i+1][l] <= x_ff[i][l] - (y_ff[i][l] >>> i);
                  y_ff[i+1][l] <= y_ff[i][l] + (x_ff[i][l] >>> i);
                  z_ff[i+1][l] <= z_ff[i][l] - atan_deg(i);
               end
            end
         end
      end

      // round half up to 7 fraction bits, saturate
      assign zr  = z_ff[CORDIC_STEPS][l] + ROUND_HALF;
      assign res = zr[CW-1:ROUND_SH];

      always_ff @(posedge clock) begin
         if (en) begin
            if (zero_ff[CORDIC_STEPS][l]) begin
               ang_ff[l] <= '0;
            end else if (res > OUT_MAX) begin
               ang_ff[l] <= OUT_MAX[ANGLE_W-1:0];
            end else if (res < -OUT_MAX) begin
               ang_ff[l] <= ANGLE_W'(-OUT_MAX);
            end else begin
               ang_ff[l] <= res[ANGLE_W-1:0];
            end
         end
      end

      assign out_angle[l] = ang_ff[l];
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[i+1] <= tag_ff[i];
         end
      end
   end

   assign out_valid = out_vld_ff;
   assign out_tag   = out_tag_ff;

endmodule

[rtl/rotation_matrix_to_euler.sv]
// Pipeline: 3 squaring stages, 18 root stages, one pre-rotation stage, 16 CORDIC
// steps and one rounding/output stage lie between input beat and result beat.
// Throughput: one matrix per cycle; the whole pipeline holds while a result
// beat waits on rsp_ready, set by the single shared stall enable.
// Reset (synchronous, active high) clears all valid bits and sets the singular
// limit to 1; no clearing pass is needed.
module rotation_matrix_to_euler import r2e_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [17:0]  req_r00,
   input  logic signed [17:0]  req_r10,
   input  logic signed [17:0]  req_r20,
   input  logic signed [17:0]  req_r21,
   input  logic signed [17:0]  req_r22,
   input  logic signed [17:0]  req_r12,
   input  logic signed [17:0]  req_r11,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_yaw_deg,
   output logic signed [15:0]  rsp_pitch_deg,
   output logic signed [15:0]  rsp_roll_deg,
   output logic                rsp_is_singular,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [16:0]         csr_singular_limit
);

   logic [LIMIT_W-1:0] limit_ff;
   logic               en;
   mat_type            req_mat;
   logic               sq_valid;
   logic [SUM_W-1:0]   sq_sum;
   mat_type            sq_mat;
   logic               rt_valid;
   logic [ROOT_W-1:0]  rt_root;
   mat_type            rt_mat;
   logic               sing;
   opd_type            opd_y [LANES];
   opd_type            opd_x [LANES];
   angle_type          angle [LANES];
   logic               cd_valid;
   logic               cd_tag;

   // one stall enable for the whole pipeline
   assign en        = !cd_valid || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_singular_limit;
      end
   end

   assign req_mat.r00 = req_r00;
   assign req_mat.r10 = req_r10;
   assign req_mat.r20 = req_r20;
   assign req_mat.r21 = req_r21;
   assign req_mat.r22 = req_r22;
   assign req_mat.r12 = req_r12;
   assign req_mat.r11 = req_r11;

   r2e_square u_square (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_mat    (req_mat),
      .out_valid (sq_valid),
      .out_sum   (sq_sum),
      .out_mat   (sq_mat)
   );

   r2e_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_sum    (sq_sum),
      .in_mat    (sq_mat),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_mat   (rt_mat)
   );

   // gimbal lock check and operand choice per lane
   assign sing = rt_root < {1'b0, limit_ff};

   assign opd_y[LANE_YAW] = -{rt_mat.r20[ENTRY_W-1], rt_mat.r20};
   assign opd_x[LANE_YAW] = {1'b0, rt_root};

   assign opd_y[LANE_PITCH] = sing ? -{rt_mat.r12[ENTRY_W-1], rt_mat.r12}
                                   :  {rt_mat.r21[ENTRY_W-1], rt_mat.r21};
   assign opd_x[LANE_PITCH] = sing ? {rt_mat.r11[ENTRY_W-1], rt_mat.r11}
                                   : {rt_mat.r22[ENTRY_W-1], rt_mat.r22};

   // zero operands give a zero angle, which is the singular roll
   assign opd_y[LANE_ROLL] = sing ? '0 : {rt_mat.r10[ENTRY_W-1], rt_mat.r10};
   assign opd_x[LANE_ROLL] = sing ? '0 : {rt_mat.r00[ENTRY_W-1], rt_mat.r00};

   r2e_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rt_valid),
      .in_tag    (sing),
      .in_y      (opd_y),
      .in_x      (opd_x),
      .out_valid (cd_valid),
      .out_tag   (cd_tag),
      .out_angle (angle)
   );

   assign rsp_valid       = cd_valid;
   assign rsp_yaw_deg     = angle[LANE_YAW];
   assign rsp_pitch_deg   = angle[LANE_PITCH];
   assign rsp_roll_deg    = angle[LANE_ROLL];
   assign rsp_is_singular = cd_tag;

endmodule

[tb/r2e_checker.sv]
`timescale 1ns / 1ps
module r2e_checker import r2e_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic signed [17:0]  req_r00,
   input  logic signed [17:0]  req_r10,
   input  logic signed [17:0]  req_r20,
   input  logic signed [17:0]  req_r21,
   input  logic signed [17:0]  req_r22,
   input  logic signed [17:0]  req_r12,
   input  logic signed [17:0]  req_r11,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic signed [15:0]  rsp_yaw_deg,
   input  logic signed [15:0]  rsp_pitch_deg,
   input  logic signed [15:0]  rsp_roll_deg,
   input  logic                rsp_is_singular,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [16:0]         csr_singular_limit,
   output int                  error_count,
   output int                  angles_pending,
   output int                  angles_seen,
   output int                  singular_seen
);

   typedef struct {
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
      logic               sing;
   } euler_type;

   // predictions wait in a ring, oldest first
   localparam int PEND_DEPTH = 64;

   euler_type       euler_mem [PEND_DEPTH];
   logic [5:0]      wr_ptr, rd_ptr;
   int              pend_count;
   logic [16:0]     limit_shadow;
   localparam longint ATAN_Q16 [24] = '{2949120, 1740967, 919879, 466945, 234379,
      117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0};

   // bit-by-bit integer square root, rounded down
   function automatic longint root_floor(longint n);
      longint res, bitv;
      res = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > n) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >>> 1) + bitv;
         end else begin
            res = res >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return res;
   endfunction

   // vectoring rotation, degrees with 7 fraction bits, saturated
   function automatic logic signed [15:0] heading(longint y, longint x);
      longint ang, nx, ny, r;
      ang = 0;
      if (x == 0 && y == 0) return '0;
      x = x * 64;
      y = y * 64;
      if (x < 0) begin
         ang = (y >= 0) ? 11796480 : -11796480;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            ang += ATAN_Q16[i];
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            ang -= ATAN_Q16[i];
         end
         x = nx;
         y = ny;
      end
      r = (ang + 256) >>> 9;
      if (r > 23040) r = 23040;
      if (r < -23040) r = -23040;
      return 16'(r);
   endfunction

   function automatic euler_type predict_euler(longint r00, longint r10, longint r20,
         longint r21, longint r22, longint r12, longint r11, logic [16:0] lim);
      euler_type e;
      longint sy;
      sy = root_floor(r00 * r00 + r10 * r10);
      e.sing = (sy < longint'(lim));
      e.yaw = heading(-r20, sy);
      if (!e.sing) begin
         e.pitch = heading(r21, r22);
         e.roll  = heading(r10, r00);
      end else begin
         e.pitch = heading(-r12, r11);
         e.roll  = '0;
      end
      return e;
   endfunction

   assign angles_pending = pend_count;

   always @(posedge clock) begin
      euler_type e;
      int adj;
      adj = 0;
      if (reset) begin
         limit_shadow <= LIMIT_RESET;
         wr_ptr <= '0;
         rd_ptr <= '0;
         pend_count <= 0;
         error_count <= 0;
         angles_seen <= 0;
         singular_seen <= 0;
      end else begin
         // compare result beat with oldest prediction
         if (rsp_valid && rsp_ready) begin
            angles_seen <= angles_seen + 1;
            if (rsp_is_singular) singular_seen <= singular_seen + 1;
            if (pend_count == 0) begin
               $display("%0t: unexpected result beat yaw %0d pitch %0d roll %0d",
                  $time, rsp_yaw_deg, rsp_pitch_deg, rsp_roll_deg);
               error_count <= error_count + 1;
            end else begin
               e = euler_mem[rd_ptr];
               rd_ptr <= rd_ptr + 6'd1;
               adj = adj - 1;
               if (e.yaw !== rsp_yaw_deg || e.pitch !== rsp_pitch_deg ||
                   e.roll !== rsp_roll_deg || e.sing !== rsp_is_singular) begin
                  $display("%0t: mismatch exp y%0d p%0d r%0d s%0b got y%0d p%0d r%0d s%0b",
                     $time, e.yaw, e.pitch, e.roll, e.sing, rsp_yaw_deg,
                     rsp_pitch_deg, rsp_roll_deg, rsp_is_singular);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            euler_mem[wr_ptr] <= predict_euler(req_r00, req_r10, req_r20, req_r21,
               req_r22, req_r12, req_r11, limit_shadow);
            wr_ptr <= wr_ptr + 6'd1;
            adj = adj + 1;
         end
         pend_count <= pend_count + adj;
         if (csr_valid && csr_ready) limit_shadow <= csr_singular_limit;
      end
   end

endmodule

[tb/tb_rotation_matrix_to_euler.sv]
`timescale 1ns / 1ps
module tb_rotation_matrix_to_euler import r2e_pkg::*;;

   localparam int WATCHDOG = 20000;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   logic signed [17:0] req_r00, req_r10, req_r20, req_r21, req_r22, req_r12, req_r11;
   logic signed [15:0] rsp_yaw_deg, rsp_pitch_deg, rsp_roll_deg;
   logic rsp_is_singular;
   logic [16:0] csr_singular_limit;
   int error_count, angles_pending, angles_seen, singular_seen;
   int idle_cycles;
   bit calm, hold_long;
   bit [16:0] limit_steps [5] = '{17'd1, 17'd0, 17'd65536, 17'd40000, 17'd131071};

   rotation_matrix_to_euler dut (.*);
   r2e_checker chk (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // receiver: random stall bursts, one long hold-off
   initial begin
      int n;
      rsp_ready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_long) begin
            rsp_ready <= 0;
            repeat (120) @(posedge clock);
            hold_long = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            @(posedge clock);
         end
      end
   end

   // watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_matrix(logic signed [17:0] a, b, c, d, e, f, g);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_r00 <= a; req_r10 <= b; req_r20 <= c; req_r21 <= d;
      req_r22 <= e; req_r12 <= f; req_r11 <= g;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_angles();
      req_valid <= 0;
      @(posedge clock);
      while (angles_pending != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic write_limit(logic [16:0] v);
      csr_valid <= 1;
      csr_singular_limit <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic signed [17:0] any_entry();
      case ($urandom_range(0, 5))
         0: any_entry = 18'($urandom);
         1: any_entry = 18'sd65536;
         2: any_entry = -18'sd65536;
         3: any_entry = 18'($urandom_range(0, 64)) - 18'sd32;
         default: any_entry = 18'($urandom_range(0, 131072)) - 18'sd65536;
      endcase
   endfunction

   initial begin
      logic signed [17:0] c, s;
      reset = 1;
      req_valid = 0; csr_valid = 0; calm = 0; hold_long = 0;
      req_r00 = 0; req_r10 = 0; req_r20 = 0; req_r21 = 0;
      req_r22 = 0; req_r12 = 0; req_r11 = 0; csr_singular_limit = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: identity, extremes, zeros, gimbal lock, out of range
      send_matrix(65536, 0, 0, 0, 65536, 0, 65536);
      send_matrix(0, 0, 0, 0, 0, 0, 0);
      send_matrix(0, 0, -65536, 0, 0, 0, 65536);
      send_matrix(0, 0, 65536, 65536, 0, -65536, 0);
      send_matrix(-65536, -65536, -65536, -65536, -65536, -65536, -65536);
      send_matrix(65536, 65536, 65536, 65536, 65536, 65536, 65536);
      send_matrix(-65536, 0, 0, 0, -65536, 0, -65536);
      send_matrix(-65536, 1, 0, -1, -65536, 1, -65536);
      send_matrix(18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF);
      send_matrix(-18'sh20000, -18'sh20000, -18'sh20000, -18'sh20000,
                  -18'sh20000, -18'sh20000, -18'sh20000);
      send_matrix(1, 0, 1, 0, -1, 0, 0);
      send_matrix(0, 1, 0, 1, 0, 1, 1);
      drain_angles();

      // random phases across limit settings
      foreach (limit_steps[k]) begin
         write_limit(limit_steps[k]);
         if (k == 1) hold_long = 1;
         if (k == 4) calm = 1;
         for (int i = 0; i < 220; i++) begin
            if ($urandom_range(0, 2) != 0) begin
               // mixed special entries, or small cosines around gimbal lock
               c = 18'($urandom_range(0, 2048)) - 18'sd1024;
               s = (c[0]) ? 18'sd65536 : -18'sd65536;
               if ($urandom_range(0, 1))
                  send_matrix(any_entry(), any_entry(), any_entry(), any_entry(),
                              any_entry(), any_entry(), any_entry());
               else
                  send_matrix(c, 18'($urandom_range(0, 2048)) - 18'sd1024, s,
                              any_entry(), any_entry(), any_entry(), any_entry());
            end else begin
               send_matrix(18'($urandom), 18'($urandom), 18'($urandom),
                           18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
            end
         end
         drain_angles();
      end

      $display("Ran %0d matrices through five singular limits, %0d of them singular.",
         angles_seen, singular_seen);
      if (error_count == 0 && angles_pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
